// File: rtl/assert_macros.svh
// Assertion macros used by the top level, the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dwlf_pkg.sv
// Types, constants and small helper functions of the LED fade ramp.
`default_nettype none
package dwlf_pkg;

  // Mode codes of the input transaction
  localparam logic [1:0] MODE_FADE_OUT = 2'd0;
  localparam logic [1:0] MODE_FADE_IN  = 2'd1;
  localparam logic [1:0] MODE_HOLD     = 2'd2;

  localparam logic [6:0]  BrightMax  = 7'd100;
  localparam logic [12:0] KelvinBase = 13'd3000;
  localparam logic [12:0] KelvinSpan = 13'd2700;  // (span / 5) reaches the gear limit
  localparam logic [9:0]  GearMax    = 10'd540;
  localparam logic [15:0] RecipFive  = 16'd52429; // ceil(2^18 / 5)
  localparam int          FiveShift  = 18;
  localparam logic [23:0] RecipTenK  = 24'd13743895; // floor(2^37 / 10000)
  localparam int          TenKShift  = 37;
  localparam logic [13:0] TenK       = 14'd10000;
  localparam logic [13:0] FadeInMul  = 14'd95;
  localparam logic [13:0] FadeInOfs  = 14'd500;
  localparam logic [13:0] FadeOutMul = 14'd100;

  localparam logic [9:0] Band0 = 10'd25;
  localparam logic [9:0] Band1 = 10'd100;
  localparam logic [9:0] Band2 = 10'd200;
  localparam logic [9:0] Band3 = 10'd400;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic calc_gear;
    logic plan;
    logic mul;
    logic div;
    logic fix;
    logic sel;      // 0 white channel, 1 yellow channel
    logic commit;
  } cmd_t;

  function automatic logic [13:0] fade_in_factor(input logic [6:0] lvl);
    return ({7'd0, lvl} * FadeInMul) + FadeInOfs;
  endfunction

  function automatic logic [4:0] step_up(input logic [9:0] gear);
    if (gear < Band0) return 5'd25;
    if (gear < Band1) return 5'd20;
    if (gear < Band2) return 5'd15;
    if (gear < Band3) return 5'd10;
    return 5'd5;
  endfunction

  function automatic logic [4:0] step_down(input logic [9:0] gear);
    if (gear < Band0) return 5'd5;
    if (gear < Band1) return 5'd10;
    if (gear < Band2) return 5'd15;
    if (gear < Band3) return 5'd20;
    return 5'd25;
  endfunction

  function automatic logic [10:0] nudge(input logic [10:0] cur, input logic [10:0] tgt);
    if (cur < tgt) return cur + 11'd1;
    if (cur > tgt) return cur - 11'd1;
    return cur;
  endfunction

endpackage
`default_nettype wire

// File: rtl/dwlf_if.sv
// Valid/ready channel interfaces for the tick input and the duty result.
`default_nettype none
interface dwlf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [6:0]  target_brightness;
  logic [12:0] target_kelvin;
  logic        snap_colour;

  modport source (output valid, mode, target_brightness, target_kelvin, snap_colour,
                  input ready);
  modport sink   (input valid, mode, target_brightness, target_kelvin, snap_colour,
                  output ready);
endinterface

interface dwlf_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] white_duty;
  logic [10:0] yellow_duty;
  logic        light_enable;

  modport source (output valid, white_duty, yellow_duty, light_enable, input ready);
  modport sink   (input valid, white_duty, yellow_duty, light_enable, output ready);
endinterface
`default_nettype wire

// File: rtl/dwlf_ctrl.sv
// Sequencing state machine: steps the datapath through one tick.
`default_nettype none
module dwlf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output dwlf_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_GEAR, S_PLAN, S_MUL, S_DIV, S_FIX, S_COMMIT
  } state_t;

  state_t state_r;
  logic   sel_r;
  logic   out_valid_r;
  logic   commit_go;

  // result slot is free, or its transaction completes this cycle
  assign commit_go = (state_r == S_COMMIT) && (!out_valid_r || out_ready);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  assign cmd.load_in   = in_valid && (state_r == S_IDLE);
  assign cmd.calc_gear = (state_r == S_GEAR);
  assign cmd.plan      = (state_r == S_PLAN);
  assign cmd.mul       = (state_r == S_MUL);
  assign cmd.div       = (state_r == S_DIV);
  assign cmd.fix       = (state_r == S_FIX);
  assign cmd.sel       = sel_r;
  assign cmd.commit    = commit_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result replaces the one taken in the same cycle
      if (commit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_GEAR;
        end
        S_GEAR: state_r <= S_PLAN;
        S_PLAN: begin
          state_r <= S_MUL;
          sel_r   <= 1'b0;
        end
        S_MUL: state_r <= S_DIV;
        S_DIV: state_r <= S_FIX;
        S_FIX: begin
          if (!sel_r) begin
            state_r <= S_MUL;
            sel_r   <= 1'b1;
          end else begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (commit_go) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/dwlf_dp.sv
// Datapath: gear, step planning, shared duty multiply/divide, lamp state.
`default_nettype none
module dwlf_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  dwlf_pkg::cmd_t  cmd,
  input  logic [1:0]      in_mode,
  input  logic [6:0]      in_target_brightness,
  input  logic [12:0]     in_target_kelvin,
  input  logic            in_snap_colour,
  output logic [10:0]     out_white_duty,
  output logic [10:0]     out_yellow_duty,
  output logic            out_light_enable
);

  typedef enum logic [1:0] {ACT_NONE, ACT_LOAD, ACT_NUDGE} act_t;

  // captured transaction
  logic [1:0]  mode_r;
  logic [6:0]  tb_r;
  logic [12:0] kelvin_r;
  logic        snap_r;

  // lamp state
  logic [6:0]  bright_r;
  logic [9:0]  colour_r;
  logic [10:0] white_r;
  logic [10:0] yellow_r;
  logic        lamp_r;

  // gear
  logic [12:0] kdiff;
  logic [27:0] gprod;
  logic [9:0]  gear_calc;
  logic [9:0]  gear_r;

  // plan
  logic [9:0]  colour_eff;
  logic [4:0]  sup;
  logic [4:0]  sdn;
  logic [10:0] col_up_sum;
  logic [9:0]  col_up;
  logic [10:0] gear_plus;
  logic [9:0]  col_dn;
  logic [6:0]  bright_mv;
  act_t        act;
  logic [6:0]  bright_n;
  logic [9:0]  colour_n;
  logic        lamp_n;
  logic [13:0] fac;
  logic [9:0]  pw;
  logic [9:0]  py;

  act_t        act_r;
  logic [6:0]  bright_n_r;
  logic [9:0]  colour_n_r;
  logic        lamp_n_r;
  logic [15:0] fac3_r;
  logic [9:0]  pw_r;
  logic [9:0]  py_r;

  // duty = fac3 * part / 10000
  logic [9:0]  part;
  logic [25:0] p_r;
  logic [49:0] qprod;
  logic [12:0] q0_r;
  logic [26:0] back;
  logic [26:0] rem;
  logic [12:0] q;
  logic [10:0] dw_r;
  logic [10:0] dy_r;

  // commit
  logic [10:0] wn;
  logic [10:0] yn;
  logic [10:0] white_fin;
  logic [10:0] yellow_fin;
  logic [9:0]  colour_fin;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r   <= in_mode;
      tb_r     <= (in_target_brightness > dwlf_pkg::BrightMax) ?
                  dwlf_pkg::BrightMax : in_target_brightness;
      kelvin_r <= in_target_kelvin;
      snap_r   <= in_snap_colour;
    end
  end

  // divide by five through a reciprocal, exact below the clamp point
  assign kdiff = kelvin_r - dwlf_pkg::KelvinBase;
  assign gprod = {16'd0, kdiff[11:0]} * {12'd0, dwlf_pkg::RecipFive};

  always_comb begin
    if (kelvin_r < dwlf_pkg::KelvinBase) begin
      gear_calc = 10'd0;
    end else if (kdiff >= dwlf_pkg::KelvinSpan) begin
      gear_calc = dwlf_pkg::GearMax;
    end else begin
      gear_calc = gprod[dwlf_pkg::FiveShift +: 10];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_gear) gear_r <= gear_calc;
  end

  always_comb begin
    colour_eff = snap_r ? gear_r : colour_r;
    sup        = dwlf_pkg::step_up(gear_r);
    sdn        = dwlf_pkg::step_down(gear_r);
    col_up_sum = {1'b0, colour_eff} + {6'd0, sup};
    col_up     = (col_up_sum > {1'b0, gear_r}) ? gear_r : col_up_sum[9:0];
    gear_plus  = {1'b0, gear_r} + {6'd0, sdn};
    col_dn     = ({1'b0, colour_eff} > gear_plus) ? (colour_eff - {5'd0, sdn}) : gear_r;
    bright_mv  = (bright_r < tb_r) ? (bright_r + 7'd1) : (bright_r - 7'd1);

    act      = ACT_NONE;
    bright_n = bright_r;
    colour_n = colour_eff;
    lamp_n   = lamp_r;
    fac      = dwlf_pkg::fade_in_factor(tb_r);
    pw       = gear_r;
    py       = dwlf_pkg::GearMax - gear_r;

    case (mode_r)
      dwlf_pkg::MODE_FADE_OUT: begin
        if (bright_r != 7'd0) begin
          act      = ACT_LOAD;
          bright_n = bright_r - 7'd1;
          fac      = {7'd0, bright_n} * dwlf_pkg::FadeOutMul;
        end else begin
          lamp_n = 1'b0;
        end
      end
      dwlf_pkg::MODE_FADE_IN: begin
        lamp_n = 1'b1;
        if (bright_r != tb_r) begin
          act      = ACT_LOAD;
          bright_n = bright_mv;
          fac      = dwlf_pkg::fade_in_factor(bright_mv);
        end else if (colour_eff != gear_r) begin
          if (colour_eff < gear_r) begin
            if (colour_eff > dwlf_pkg::GearMax) begin
              act = ACT_NUDGE;
            end else begin
              act      = ACT_LOAD;
              colour_n = col_up;
              pw       = col_up;
              py       = dwlf_pkg::GearMax - col_up;
            end
          end else begin
            if (colour_eff < dwlf_pkg::Band0) begin
              act = ACT_NUDGE;
            end else begin
              // yellow keeps the target gear on the way down
              act      = ACT_LOAD;
              colour_n = col_dn;
              pw       = col_dn;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.plan) begin
      act_r      <= act;
      bright_n_r <= bright_n;
      colour_n_r <= colour_n;
      lamp_n_r   <= lamp_n;
      fac3_r     <= {2'd0, fac} * 16'd3;
      pw_r       <= pw;
      py_r       <= py;
    end
  end

  // shared multiply, reciprocal divide and one-step correction
  assign part  = cmd.sel ? py_r : pw_r;
  assign qprod = {24'd0, p_r} * {26'd0, dwlf_pkg::RecipTenK};
  assign back  = {14'd0, q0_r} * {13'd0, dwlf_pkg::TenK};
  assign rem   = {1'b0, p_r} - back;
  assign q     = q0_r + ((rem >= {13'd0, dwlf_pkg::TenK}) ? 13'd1 : 13'd0);

  always_ff @(posedge clk) begin
    if (cmd.mul) p_r <= {10'd0, fac3_r} * {16'd0, part};
    if (cmd.div) q0_r <= qprod[dwlf_pkg::TenKShift +: 13];
    if (cmd.fix) begin
      if (cmd.sel) dy_r <= q[10:0];
      else         dw_r <= q[10:0];
    end
  end

  always_comb begin
    wn         = dwlf_pkg::nudge(white_r, dw_r);
    yn         = dwlf_pkg::nudge(yellow_r, dy_r);
    white_fin  = white_r;
    yellow_fin = yellow_r;
    colour_fin = colour_n_r;
    case (act_r)
      ACT_LOAD: begin
        white_fin  = dw_r;
        yellow_fin = dy_r;
      end
      ACT_NUDGE: begin
        white_fin  = wn;
        yellow_fin = yn;
        if ((wn == dw_r) || (yn == dy_r)) colour_fin = gear_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= 7'd0;
      colour_r <= 10'd0;
      white_r  <= 11'd0;
      yellow_r <= 11'd0;
      lamp_r   <= 1'b0;
    end else if (cmd.commit) begin
      bright_r <= bright_n_r;
      colour_r <= colour_fin;
      white_r  <= white_fin;
      yellow_r <= yellow_fin;
      lamp_r   <= lamp_n_r;
    end
  end

  // the result is the committed state, held until the next commit
  assign out_white_duty   = white_r;
  assign out_yellow_duty  = yellow_r;
  assign out_light_enable = lamp_r;

endmodule
`default_nettype wire

// File: rtl/dual_white_led_fade_ramp_top.sv
// Top level of the dual white LED fade and colour ramp.
//
// in_ch carries one tick transaction: mode, target brightness, target
// kelvin and the snap flag. out_ch returns one transaction per tick with
// the cool white and warm yellow duties and the lamp enable.
// A tick is taken when in_ch.ready is high, which is only while the block
// is idle. The result goes valid after the input transaction has passed
// through gear, plan, then two passes of multiply, reciprocal divide and
// correction through one shared duty unit, then the commit. A new tick is
// taken the cycle after commit. The result sits in the lamp state registers;
// a stalled receiver does not block the next tick, which runs up to its
// commit and waits there until the pending result has been taken.
// Synchronous reset clears the brightness, colour level, both duties and
// the enable, and leaves both channels empty.
`default_nettype none
`include "assert_macros.svh"
module dual_white_led_fade_ramp_top (
  input  logic        clk,
  input  logic        rst_n,
  dwlf_in_if.sink     in_ch,
  dwlf_out_if.source  out_ch
);

  dwlf_pkg::cmd_t cmd;

  dwlf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  dwlf_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_mode              (in_ch.mode),
    .in_target_brightness (in_ch.target_brightness),
    .in_target_kelvin     (in_ch.target_kelvin),
    .in_snap_colour       (in_ch.snap_colour),
    .out_white_duty       (out_ch.white_duty),
    .out_yellow_duty      (out_ch.yellow_duty),
    .out_light_enable     (out_ch.light_enable)
  );

  `ASSERT_NEXT(a_one_tick_at_a_time, clk, rst_n,
               in_ch.valid && in_ch.ready, !in_ch.ready,
               "tick accepted while busy")
  `ASSERT_IMPLIES(a_duty_range, clk, rst_n, out_ch.valid,
                  (out_ch.white_duty <= 11'd1620) && (out_ch.yellow_duty <= 11'd1620),
                  "duty out of range")

endmodule
`default_nettype wire
